FILE: hdl/gf2ip_pkg.sv
// shared types and constants for the gf(2) irreducible polynomial search
// no dependencies; compiled first
package gf2ip_pkg;

	// payload and register widths
	localparam int HOW_MANY_W  = 7;
	localparam int POLY_OUT_W  = 32;
	localparam int WINDOW_W    = 16;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 1;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_START_CANDIDATE = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_WINDOW   = 1'b1;

	// reset values
	localparam logic [CFG_DATA_W-1:0] RESET_START  = 32'd2;
	localparam logic [WINDOW_W-1:0]   RESET_WINDOW = 16'd5000;

	// trial division unit states
	typedef enum logic [1:0] {
		T_IDLE,
		T_SCAN,
		T_CHECK,
		T_DIV
	} trial_state_t;

	// search sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_BEGIN,
		S_LAUNCH,
		S_WAIT,
		S_OUT
	} search_state_t;

	// verdict from the trial division unit
	typedef struct packed {
		logic done;
		logic irred;
	} trial_status_t;

endpackage

FILE: hdl/gf2ip_if.sv
// request and result channel interfaces for the irreducible polynomial search
// depends on gf2ip_pkg
interface gf2ip_req_if import gf2ip_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [HOW_MANY_W-1:0] how_many;

	modport source (output valid, output how_many, input ready);
	modport sink (input valid, input how_many, output ready);
endinterface

interface gf2ip_res_if import gf2ip_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [POLY_OUT_W-1:0] poly;
	logic                  found;
	logic                  last;

	modport source (output valid, output poly, output found, output last, input ready);
	modport sink (input valid, input poly, input found, input last, output ready);
endinterface

FILE: hdl/gf2ip_trial_div.sv
// irreducibility test of one candidate by bit-serial gf(2) trial division
// depends on gf2ip_pkg
module gf2ip_trial_div import gf2ip_pkg::*; #(
	parameter int POLY_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [POLY_WIDTH-1:0] cand,
	output trial_status_t         status
);

	localparam int DW = $clog2(POLY_WIDTH);

	trial_state_t state_q, state_d;

	logic [POLY_WIDTH-1:0] c_q, d_q, r_q;
	logic [DW-1:0]         pos_q, dc_q, dd_q, i_q;

	logic [POLY_WIDTH-1:0] shifted, r_next, d_inc;
	logic                  dd_bump, lim_hit, c_small;

	// one long-division step: bring down the next candidate bit, subtract divisor
	assign shifted = {r_q[POLY_WIDTH-2:0], c_q[i_q]};
	assign r_next  = shifted[dd_q] ? (shifted ^ d_q) : shifted;
	assign d_inc   = d_q + POLY_WIDTH'(1);
	assign dd_bump = (d_inc & d_q) == '0;
	assign lim_hit = dd_q > (dc_q >> 1);
	assign c_small = c_q < POLY_WIDTH'(2);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and verdict
	always_comb begin
		state_d      = state_q;
		status.done  = 1'b0;
		status.irred = 1'b0;
		unique case (state_q)
			T_IDLE: begin
				if (start) state_d = T_SCAN;
			end
			T_SCAN: begin
				if (c_small) begin
					status.done = 1'b1;
					state_d     = T_IDLE;
				end else if (c_q[pos_q]) begin
					state_d = T_CHECK;
				end
			end
			T_CHECK: begin
				if (lim_hit) begin
					status.done  = 1'b1;
					status.irred = 1'b1;
					state_d      = T_IDLE;
				end else begin
					state_d = T_DIV;
				end
			end
			T_DIV: begin
				if (i_q == '0) begin
					if (r_next == '0) begin
						status.done = 1'b1;
						state_d     = T_IDLE;
					end else begin
						state_d = T_CHECK;
					end
				end
			end
			default: state_d = T_IDLE;
		endcase
	end

	// datapath: degree scan, divisor walk and remainder
	always_ff @(posedge clk) begin
		case (state_q)
			T_IDLE: begin
				if (start) begin
					c_q   <= cand;
					pos_q <= DW'(POLY_WIDTH - 1);
				end
			end
			T_SCAN: begin
				pos_q <= pos_q - DW'(1);
				dc_q  <= pos_q;
				d_q   <= POLY_WIDTH'(2);
				dd_q  <= DW'(1);
			end
			T_CHECK: begin
				r_q <= '0;
				i_q <= dc_q;
			end
			T_DIV: begin
				r_q <= r_next;
				i_q <= i_q - DW'(1);
				if (i_q == '0) begin
					d_q <= d_inc;
					if (dd_bump) dd_q <= dd_q + DW'(1);
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: hdl/gf2_irreducible_polynomial_search.sv
// steps per result: a begin step, then per candidate a launch, a degree scan from the top bit and
// a trial division for each divisor below 2^(deg/2 + 1), plus a closing check on a hit, all on the
// one bit-serial trial division unit; candidates 0 and 1 end at the scan; a miss after a miss or
// with a zero window goes straight from the begin step to the result beat.
// one request at a time: the next request is taken after the last result beat of this one.
// reset: next candidate 2, search window 5000, sequencer idle, no result pending.
module gf2_irreducible_polynomial_search import gf2ip_pkg::*; #(
	parameter int POLY_WIDTH = 32,
	parameter int MAX_BATCH  = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	gf2ip_req_if.sink              req,
	gf2ip_res_if.source            res,
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data
);

	localparam int CNT_W = $clog2(MAX_BATCH + 1);

	search_state_t state_q, state_d;

	logic [POLY_WIDTH-1:0] next_q, cand_q;
	logic [WINDOW_W-1:0]   window_q, t_q, t_next;
	logic [CNT_W-1:0]      left_q, req_count;
	logic                  missed_q, found_q, start;
	logic [POLY_OUT_W-1:0] poly_q;
	logic [63:0]           wr_ext, cand_ext;
	trial_status_t         status;

	// candidate test unit
	gf2ip_trial_div #(
		.POLY_WIDTH(POLY_WIDTH)
	) u_trial (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cand   (cand_q),
		.status (status)
	);

	// request size, saturated to the batch limit
	assign req_count = (req.how_many > HOW_MANY_W'(MAX_BATCH)) ? CNT_W'(MAX_BATCH)
	                                                           : CNT_W'(req.how_many);
	assign t_next    = t_q + WINDOW_W'(1);
	assign wr_ext    = 64'(wr_data);
	assign cand_ext  = 64'(cand_q);

	// result beat
	assign res.valid = state_q == S_OUT;
	assign res.poly  = poly_q;
	assign res.found = found_q;
	assign res.last  = left_q == CNT_W'(1);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer next state
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		start     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid && req_count != '0) state_d = S_BEGIN;
			end
			S_BEGIN: begin
				if (missed_q || window_q == '0) state_d = S_OUT;
				else state_d = S_LAUNCH;
			end
			S_LAUNCH: begin
				start   = 1'b1;
				state_d = S_WAIT;
			end
			S_WAIT: begin
				if (status.done) begin
					if (status.irred || t_next == window_q) state_d = S_OUT;
					else state_d = S_LAUNCH;
				end
			end
			S_OUT: begin
				if (res.ready) begin
					if (left_q == CNT_W'(1)) state_d = S_IDLE;
					else state_d = S_BEGIN;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q   <= POLY_WIDTH'(RESET_START);
			window_q <= RESET_WINDOW;
			left_q   <= '0;
			missed_q <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_START_CANDIDATE: next_q   <= wr_ext[POLY_WIDTH-1:0];
					REG_SEARCH_WINDOW:   window_q <= wr_data[WINDOW_W-1:0];
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						left_q   <= req_count;
						missed_q <= 1'b0;
					end
				end
				S_BEGIN: begin
					if (window_q == '0) missed_q <= 1'b1;
				end
				S_WAIT: begin
					if (status.done) begin
						if (status.irred) next_q <= cand_q + POLY_WIDTH'(1);
						else if (t_next == window_q) missed_q <= 1'b1;
					end
				end
				S_OUT: begin
					if (res.ready) left_q <= left_q - CNT_W'(1);
				end
				default: ;
			endcase
		end
	end

	// candidate walk and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_BEGIN: begin
				cand_q  <= next_q;
				t_q     <= '0;
				poly_q  <= '0;
				found_q <= 1'b0;
			end
			S_WAIT: begin
				if (status.done) begin
					if (status.irred) begin
						poly_q  <= cand_ext[POLY_OUT_W-1:0];
						found_q <= 1'b1;
					end else begin
						t_q    <= t_next;
						cand_q <= cand_q + POLY_WIDTH'(1);
					end
				end
			end
			default: ;
		endcase
	end

	// the test unit only reports while the sequencer waits for it
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		status.done |-> state_q == S_WAIT)
		else $error("trial unit verdict outside wait");

	// a miss always carries a zero polynomial
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.found |-> res.poly == '0)
		else $error("miss beat with nonzero polynomial");

	// once a request has missed, no later beat of it reports a hit
	a_miss_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && missed_q |-> !res.found)
		else $error("hit reported after a miss");

	// no new request is taken while a result beat is pending
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !req.ready)
		else $error("request accepted while result pending");

endmodule

FILE: bench/tb.sv
// self-checking testbench for the gf(2) irreducible polynomial search
// depends on gf2ip_pkg, gf2ip_req_if / gf2ip_res_if and the search block itself
`timescale 1ns / 100ps

module tb import gf2ip_pkg::*; ();

	localparam int MAX_BATCH    = 64;
	localparam int DRAIN_CYCLES = 100;
	localparam int CYCLE_LIMIT  = 200_000_000;
	localparam int RANDOM_ITEMS = 110;
	localparam int REPORT_MAX   = 10;
	localparam int DIRECTED_N   = 19;

	// one result beat as seen on the result channel
	typedef struct packed {
		logic [POLY_OUT_W-1:0] poly;
		logic                  found;
		logic                  last;
	} poly_beat_t;

	// one directed row: optional register writes, then a request
	typedef struct packed {
		bit                    set_start;
		logic [CFG_DATA_W-1:0] start;
		bit                    set_window;
		logic [CFG_DATA_W-1:0] window;
		logic [HOW_MANY_W-1:0] count;
		bit                    typed;
		logic [POLY_OUT_W-1:0] t_poly;
		bit                    t_found;
	} step_t;

	// random phase flavors
	typedef enum {
		PH_SEARCH,
		PH_TIGHT,
		PH_HIGH_MISS,
		PH_NO_WINDOW,
		PH_CONTINUE
	} phase_t;

	logic clk;
	logic arst_n;
	logic                   wr_en;
	logic [CFG_INDEX_W-1:0] wr_index;
	logic [CFG_DATA_W-1:0]  wr_data;

	gf2ip_req_if req_bus ();
	gf2ip_res_if res_bus ();

	gf2_irreducible_polynomial_search DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_bus),
		.res      (res_bus),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// mirrored block state
	logic [POLY_OUT_W-1:0] model_next;
	logic [WINDOW_W-1:0]   model_window;

	poly_beat_t pending_polys[$];
	int  mismatches;
	int  cycles;
	bit  steady_sender;

	// directed rows; typed expectations cover the first result only
	step_t steps [DIRECTED_N] = '{
		'{1'b0, 32'd0, 1'b0, 32'd0, 7'd1, 1'b1, 32'd2, 1'b1},          // first hit after reset is x
		'{1'b0, 32'd0, 1'b0, 32'd0, 7'd3, 1'b0, 32'd0, 1'b0},
		'{1'b0, 32'd0, 1'b0, 32'd0, 7'd0, 1'b0, 32'd0, 1'b0},          // empty request
		'{1'b0, 32'd0, 1'b0, 32'd0, 7'd127, 1'b0, 32'd0, 1'b0},        // clipped to full batch
		'{1'b0, 32'd0, 1'b1, 32'd0, 7'd2, 1'b1, 32'd0, 1'b0},          // zero window misses
		'{1'b1, 32'hFFFF_FFFF, 1'b1, 32'd4, 7'd1, 1'b1, 32'd2, 1'b1},  // wraps through 0, 1 to x
		'{1'b1, 32'hFFFF_FFFF, 1'b1, 32'd3, 7'd2, 1'b1, 32'd0, 1'b0},  // wraps, zero and one rejected
		'{1'b1, 32'd0, 1'b1, 32'd1, 7'd1, 1'b1, 32'd0, 1'b0},          // zero is not irreducible
		'{1'b1, 32'd1, 1'b1, 32'd1, 7'd1, 1'b1, 32'd0, 1'b0},          // one is not irreducible
		'{1'b1, 32'd0, 1'b1, 32'd3, 7'd1, 1'b1, 32'd2, 1'b1},
		'{1'b1, 32'h8000_0000, 1'b1, 32'd1, 7'd127, 1'b1, 32'd0, 1'b0},
		'{1'b1, 32'hFFFF_FFFE, 1'b1, 32'd1, 7'd64, 1'b1, 32'd0, 1'b0},
		'{1'b1, 32'd2, 1'b1, 32'hFFFF_FFFF, 7'd65, 1'b0, 32'd0, 1'b0}, // widest window
		'{1'b1, 32'd4, 1'b1, 32'd1, 7'd2, 1'b1, 32'd0, 1'b0},
		'{1'b1, 32'd4, 1'b1, 32'd4, 7'd3, 1'b0, 32'd0, 1'b0},
		'{1'b1, 32'd1024, 1'b1, 32'd200, 7'd4, 1'b0, 32'd0, 1'b0},
		'{1'b0, 32'd0, 1'b0, 32'd0, 7'd1, 1'b0, 32'd0, 1'b0},
		'{1'b1, 32'd2, 1'b1, 32'd5000, 7'd2, 1'b1, 32'd2, 1'b1},
		'{1'b0, 32'd0, 1'b1, 32'd1, 7'd5, 1'b1, 32'd0, 1'b0}           // stuck on a reducible one
	};

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// highest set coefficient, -1 for the zero polynomial
	function automatic int poly_degree(logic [POLY_OUT_W-1:0] v);
		for (int k = POLY_OUT_W - 1; k >= 0; k--)
			if (v[k]) return k;
		return -1;
	endfunction

	// shift-and-xor remainder of a by b
	function automatic logic [POLY_OUT_W-1:0] gf2_mod(logic [POLY_OUT_W-1:0] a,
			logic [POLY_OUT_W-1:0] b);
		int da;
		int db;
		db = poly_degree(b);
		da = poly_degree(a);
		while (da >= db) begin
			a = a ^ (b << (da - db));
			da = poly_degree(a);
		end
		return a;
	endfunction

	// trial division by every divisor up to half the degree
	function automatic bit is_irreducible(logic [POLY_OUT_W-1:0] c);
		int          dc;
		logic [32:0] lim;
		logic [32:0] d;
		dc = poly_degree(c);
		if (c < 2) return 1'b0;
		if (dc == 1) return 1'b1;
		lim = 33'd1 << (dc / 2 + 1);
		for (d = 33'd2; d < lim; d++)
			if (gf2_mod(c, d[POLY_OUT_W-1:0]) == '0) return 1'b0;
		return 1'b1;
	endfunction

	// expected beats of one request; advances the mirrored next candidate
	function automatic void search_irreducibles(input logic [HOW_MANY_W-1:0] count,
			ref poly_beat_t beats[$]);
		int                    n;
		bit                    missed;
		logic [POLY_OUT_W-1:0] c;
		poly_beat_t            b;
		n = (count > MAX_BATCH) ? MAX_BATCH : int'(count);
		missed = 1'b0;
		for (int k = 0; k < n; k++) begin
			b.poly = '0;
			b.found = 1'b0;
			b.last = (k == n - 1);
			// after a miss the rest of the request misses too
			if (!missed) begin
				c = model_next;
				for (int t = 0; t < int'(model_window); t++) begin
					if (is_irreducible(c)) begin
						b.poly = c;
						b.found = 1'b1;
						model_next = c + 1'b1;
						break;
					end
					c = c + 1'b1;
				end
				missed = !b.found;
			end
			beats = {beats, b};
		end
	endfunction

	// idle length: mostly short, a few long
	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 15);
		return $urandom_range(30, 120);
	endfunction

	// one request beat; valid stays up so a back-to-back request needs no toggle
	task automatic send_request(input logic [HOW_MANY_W-1:0] count, input bit typed,
			input logic [POLY_OUT_W-1:0] t_poly, input bit t_found);
		int         gap;
		poly_beat_t beats[$];
		gap = steady_sender ? 0 : idle_span();
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.how_many <= count;
		@(posedge clk);
		while (!req_bus.ready) @(posedge clk);
		search_irreducibles(count, beats);
		if (typed && beats.size() > 0) begin
			beats[0].poly = t_poly;
			beats[0].found = t_found;
		end
		foreach (beats[k]) pending_polys = {pending_polys, beats[k]};
	endtask

	// drop valid, wait for every expected beat, let the block go idle
	task automatic settle();
		req_bus.valid <= 1'b0;
		while (pending_polys.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register writes, only while idle
	task automatic write_regs(input bit ws, input logic [CFG_DATA_W-1:0] start,
			input bit ww, input logic [CFG_DATA_W-1:0] wdata);
		if (ws) begin
			wr_en <= 1'b1;
			wr_index <= REG_START_CANDIDATE;
			wr_data <= start;
			@(posedge clk);
			model_next = start;
		end
		if (ww) begin
			wr_en <= 1'b1;
			wr_index <= REG_SEARCH_WINDOW;
			wr_data <= wdata;
			@(posedge clk);
			model_window = wdata[WINDOW_W-1:0];
		end
		wr_en <= 1'b0;
	endtask

	task automatic report_mismatch(input poly_beat_t want, input poly_beat_t got,
			input bit stray);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			if (stray)
				$display("%0t: unexpected beat poly %h found %b last %b",
					$realtime, got.poly, got.found, got.last);
			else
				$display("%0t: mismatch poly exp %h got %h, found exp %b got %b, last exp %b got %b",
					$realtime, want.poly, got.poly, want.found, got.found, want.last, got.last);
		end
	endtask

	// result side back-pressure
	initial begin : result_ready
		int run;
		int gap;
		res_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			run = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 16);
			res_bus.ready <= 1'b1;
			repeat (run) @(posedge clk);
			gap = idle_span();
			if (gap > 0) begin
				res_bus.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// compare each accepted result beat with the oldest expectation
	always @(posedge clk) begin : result_check
		poly_beat_t got;
		poly_beat_t want;
		if (arst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
			got.poly = res_bus.poly;
			got.found = res_bus.found;
			got.last = res_bus.last;
			if (pending_polys.size() == 0) begin
				report_mismatch(got, got, 1'b1);
			end else begin
				want = pending_polys.pop_front();
				if (got.poly !== want.poly || got.found !== want.found ||
						got.last !== want.last)
					report_mismatch(want, got, 1'b0);
			end
		end
	end

	// run limit
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// stimulus
	initial begin : stimulus
		phase_t                mode;
		int                    r;
		int                    items;
		int                    rand_items;
		logic [CFG_DATA_W-1:0] start;
		logic [CFG_DATA_W-1:0] w;
		logic [WINDOW_W-1:0]   win;
		logic [HOW_MANY_W-1:0] count;
		bit                    ws;

		mismatches = 0;
		steady_sender = 1'b0;
		model_next = RESET_START;
		model_window = RESET_WINDOW;
		arst_n <= 1'b0;
		req_bus.valid <= 1'b0;
		req_bus.how_many <= '0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		foreach (steps[i]) begin
			if (steps[i].set_start || steps[i].set_window) begin
				settle();
				write_regs(steps[i].set_start, steps[i].start, steps[i].set_window,
					steps[i].window);
			end
			send_request(steps[i].count, steps[i].typed, steps[i].t_poly, steps[i].t_found);
		end

		// random phases, each with its own register setting
		rand_items = 0;
		while (rand_items < RANDOM_ITEMS) begin
			r = $urandom_range(0, 9);
			if (r < 5) mode = PH_SEARCH;
			else if (r == 5) mode = PH_TIGHT;
			else if (r == 6) mode = PH_HIGH_MISS;
			else if (r == 7) mode = PH_NO_WINDOW;
			else mode = PH_CONTINUE;
			steady_sender = ($urandom_range(0, 3) == 0);
			settle();

			// upper window data bits are don't-care, keep them random
			w = $urandom();
			ws = 1'b1;
			case (mode)
				PH_SEARCH: begin
					start = $urandom_range(2, 700);
					win = WINDOW_W'($urandom_range(16, 65535));
				end
				PH_TIGHT: begin
					start = $urandom_range(0, 300);
					win = WINDOW_W'($urandom_range(0, 6));
				end
				PH_HIGH_MISS: begin
					// even candidates fall to the divisor x at once
					start = $urandom() & 32'hFFFF_FFFE;
					win = 16'd1;
				end
				PH_NO_WINDOW: begin
					start = $urandom();
					win = '0;
				end
				default: begin
					start = $urandom_range(2, 700);
					win = WINDOW_W'($urandom_range(16, 65535));
					ws = (model_next >= 1500);
				end
			endcase
			write_regs(ws, start, 1'b1, {w[CFG_DATA_W-1:WINDOW_W], win});

			items = $urandom_range(6, 14);
			for (int k = 0; k < items && rand_items < RANDOM_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				case (mode)
					PH_TIGHT:
						count = (r < 30) ? HOW_MANY_W'($urandom_range(0, 127)) :
							HOW_MANY_W'($urandom_range(1, 6));
					PH_HIGH_MISS, PH_NO_WINDOW:
						count = HOW_MANY_W'($urandom_range(0, 127));
					default:
						count = (r < 6) ? '0 : (r < 88) ? HOW_MANY_W'($urandom_range(1, 4)) :
							HOW_MANY_W'($urandom_range(5, 12));
				endcase
				// now and then hold off until the block has drained
				if ($urandom_range(0, 9) == 0) settle();
				send_request(count, 1'b0, '0, 1'b0);
				rand_items++;
			end
		end

		settle();
		if (mismatches == 0 && pending_polys.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
